/* hdl/fspa_pkg.sv */
package fspa_pkg;

    localparam int ADDR_W    = 48;
    localparam int STRIDE_W  = 17;
    localparam int CNT_W     = 11;
    localparam int SIZE_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int OFS_W     = STRIDE_W + CNT_W;
    localparam int SLOTS_DEF = 1024;

    localparam logic [CNT_W-1:0] USED_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 2'd2;

    localparam logic [ADDR_W-1:0]   BASE_RST   = 48'd4096;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 17'd8;
    localparam logic [CNT_W-1:0]    SLOTS_RST  = 11'd0;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REBUILD = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef struct packed {
        t_op               opcode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] freed_address;
    } t_req;

    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] slot_address;
        logic [CNT_W-1:0]  used_count;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic mul_go;
        logic rd_link;
        logic alloc_commit;
        logic div_init;
        logic div_step;
        logic free_commit;
        logic rb_step;
        logic rb_finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic alloc_ok;
        logic in_range;
        logic div_last;
        logic rb_empty;
        logic rb_last;
    } t_sts;

endpackage

/* hdl/fspa_dp.sv */
module fspa_dp
    import fspa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    input  t_req                 i_req,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output t_rsp                 o_rsp
);

    localparam int LW     = $clog2(SLOTS + 1);
    localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MA_W   = (LW > CNT_W) ? LW : CNT_W;
    localparam int PROD_W = MA_W + STRIDE_W;
    localparam logic [LW-1:0]    END_MARK = LW'(SLOTS);
    localparam logic [CNT_W-1:0] ACT_MAX  = (SLOTS >= 2047) ? '1 : CNT_W'(SLOTS);

    logic [ADDR_W-1:0]   r_base;
    logic [STRIDE_W-1:0] r_stride;
    logic [CNT_W-1:0]    r_slots_cfg;
    logic [LW-1:0]       r_head;
    logic [CNT_W-1:0]    r_used;
    t_op                 r_op;
    logic [SIZE_W-1:0]   r_size;
    logic [ADDR_W-1:0]   r_addr;
    logic [PROD_W-1:0]   r_prod;
    logic [LW-1:0]       r_link_rd;
    logic [OFS_W-1:0]    r_rem;
    logic [OFS_W-1:0]    r_div;
    logic [CNT_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_gnt;
    logic [ADDR_W-1:0]   r_saddr;
    t_rsp                r_out;
    logic [LW-1:0]       r_link_mem [SLOTS];

    logic [CNT_W-1:0]  w_active;
    logic [MA_W-1:0]   w_mul_a;
    logic [ADDR_W:0]   w_end;
    logic [ADDR_W-1:0] w_ofs;
    logic              w_in_range;
    logic              w_idx_ok;
    logic [CNT_W:0]    w_rb_nxt;
    logic              w_rb_last;
    logic [LW-1:0]     w_rb_link;
    logic              w_mem_we;
    logic [IW-1:0]     w_mem_waddr;
    logic [LW-1:0]     w_mem_wdata;

    // slots_in_use above SLOTS acts as SLOTS
    assign w_active = (r_slots_cfg > ACT_MAX) ? ACT_MAX : r_slots_cfg;
    assign w_mul_a  = (r_op == OP_ALLOC) ? MA_W'(r_head) : MA_W'(w_active);

    assign w_end      = (ADDR_W+1)'(r_base) + (ADDR_W+1)'(r_prod);
    assign w_ofs      = r_addr - r_base;
    assign w_in_range = (r_addr != '0) && (r_stride != '0) && (r_addr >= r_base)
                        && ((ADDR_W+1)'(r_addr) < w_end);
    assign w_idx_ok   = 32'(r_quo) < SLOTS;

    assign w_rb_nxt  = (CNT_W+1)'(r_cnt) + (CNT_W+1)'(1);
    assign w_rb_last = w_rb_nxt == (CNT_W+1)'(w_active);
    assign w_rb_link = w_rb_last ? END_MARK : LW'(w_rb_nxt);

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = IW'(r_cnt);
        w_mem_wdata = w_rb_link;
        if (i_cmd.free_commit && w_idx_ok) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = IW'(r_quo);
            w_mem_wdata = r_head;
        end else if (i_cmd.rb_step) begin
            w_mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_link_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (i_cmd.rd_link) begin
            r_link_rd <= r_link_mem[IW'(r_head)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RST;
            r_stride    <= STRIDE_RST;
            r_slots_cfg <= SLOTS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BASE) begin
                r_base <= i_cfg_wdata;
            end
            if (i_cfg_idx == CFG_STRIDE) begin
                r_stride <= i_cfg_wdata[STRIDE_W-1:0];
            end
            if (i_cfg_idx == CFG_SLOTS) begin
                r_slots_cfg <= i_cfg_wdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= END_MARK;
            r_used <= '0;
        end else if (i_cmd.alloc_commit) begin
            r_head <= r_link_rd;
            if (r_used != USED_MAX) begin
                r_used <= r_used + CNT_W'(1);
            end
        end else if (i_cmd.free_commit && w_idx_ok) begin
            r_head <= LW'(r_quo);
            if (r_used != '0) begin
                r_used <= r_used - CNT_W'(1);
            end
        end else if (i_cmd.rb_finish) begin
            r_head <= (w_active != '0) ? '0 : END_MARK;
            r_used <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req.opcode;
            r_size <= i_req.request_size;
            r_addr <= i_req.freed_address;
        end
        if (i_cmd.mul_go) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(r_stride);
        end
    end

    // restoring divider, one quotient bit per step, MSB first
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.div_init) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step || i_cmd.rb_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.div_init) begin
            r_rem <= w_ofs[OFS_W-1:0];
            r_div <= {1'b0, r_stride, {(CNT_W-1){1'b0}}};
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_div) begin
                r_rem <= r_rem - r_div;
                r_quo <= {r_quo[CNT_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[CNT_W-2:0], 1'b0};
            end
            r_div <= r_div >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gnt   <= 1'b0;
            r_saddr <= '0;
        end else if (i_cmd.alloc_commit) begin
            r_gnt   <= 1'b1;
            r_saddr <= r_base + ADDR_W'(r_prod);
        end else if (i_cmd.free_commit && w_idx_ok) begin
            r_gnt <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.granted      <= r_gnt;
            r_out.slot_address <= r_saddr;
            r_out.used_count   <= r_used;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.alloc_ok = (SIZE_W'(r_stride) >= r_size) && (32'(r_head) < SLOTS);
    assign o_sts.in_range = w_in_range;
    assign o_sts.div_last = r_cnt == CNT_W'(CNT_W - 1);
    assign o_sts.rb_empty = w_active == '0;
    assign o_sts.rb_last  = w_rb_last;
    assign o_rsp          = r_out;

endmodule

/* hdl/fspa_ctrl.sv */
module fspa_ctrl
    import fspa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECODE  = 8'b0000_0010,
        S_ALLOC   = 8'b0000_0100,
        S_FCHK    = 8'b0000_1000,
        S_FDIV    = 8'b0001_0000,
        S_FPUSH   = 8'b0010_0000,
        S_REBUILD = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.mul_go = 1'b1;
                unique case (i_sts.op)
                    OP_ALLOC: begin
                        if (i_sts.alloc_ok) begin
                            o_cmd.rd_link = 1'b1;
                            n_state       = S_ALLOC;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_FREE: begin
                        n_state = S_FCHK;
                    end
                    OP_REBUILD: begin
                        if (i_sts.rb_empty) begin
                            o_cmd.rb_finish = 1'b1;
                            n_state         = S_DONE;
                        end else begin
                            n_state = S_REBUILD;
                        end
                    end
                    OP_NOP: begin
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ALLOC: begin
                o_cmd.alloc_commit = 1'b1;
                n_state            = S_DONE;
            end
            S_FCHK: begin
                o_cmd.div_init = 1'b1;
                n_state        = i_sts.in_range ? S_FDIV : S_DONE;
            end
            S_FDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FPUSH;
                end
            end
            S_FPUSH: begin
                o_cmd.free_commit = 1'b1;
                n_state           = S_DONE;
            end
            S_REBUILD: begin
                o_cmd.rb_step = 1'b1;
                if (i_sts.rb_last) begin
                    o_cmd.rb_finish = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

    a_div_to_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FDIV && i_sts.div_last) |=> (r_state == S_FPUSH))
        else $error("divider did not finish into push");

    a_done_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_state == S_IDLE && r_out_valid))
        else $error("result not posted");
`endif

endmodule

/* hdl/fixed_slot_pool_allocator.sv */
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_ready    i_in_req   (t_req)
// response  out        o_out_valid / i_out_ready  o_out_rsp  (t_rsp)
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
// An allocate reads the link memory and commits; a free range-checks the address, runs the
// one-bit-per-cycle restoring divider and pushes the slot; a rebuild writes one link memory
// entry per cycle; a refused allocate or a no-op goes straight to the result.
// One request in flight; the next is taken while a result waits in the output register.
// Synchronous active-low reset: empty list, used count zero, configuration defaults.
// The link memory has no clear pass; entries are written by free and rebuild.
module fixed_slot_pool_allocator
    import fspa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_req                 i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_rsp                 o_out_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    fspa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    fspa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_in_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp       (o_out_rsp)
    );

endmodule

/* tb/tb_fixed_slot_pool_allocator.sv */
module tb_fixed_slot_pool_allocator;
    import fspa_pkg::*;

    localparam int NSLOTS = SLOTS_DEF;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_req                 i_in_req    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_rsp                 o_out_rsp;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_BASE;
    logic [ADDR_W-1:0]    i_cfg_wdata = '0;

    fixed_slot_pool_allocator #(.SLOTS(NSLOTS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the pool: configuration, link memory, head, used count
    logic [ADDR_W-1:0]   m_base;
    logic [STRIDE_W-1:0] m_stride;
    logic [CNT_W-1:0]    m_slots;
    int unsigned         m_link [NSLOTS];
    int unsigned         m_head;
    logic [CNT_W-1:0]    m_used;

    t_rsp pending_rsp [$];

    int n_err      = 0;
    int n_req      = 0;
    int n_rsp      = 0;
    int n_alloc_ok = 0;
    int n_free_ok  = 0;
    int n_phases   = 0;

    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;

    function automatic void pool_reset();
        m_base   = BASE_RST;
        m_stride = STRIDE_RST;
        m_slots  = SLOTS_RST;
        m_head   = NSLOTS;
        m_used   = '0;
    endfunction

    function automatic t_rsp pool_step(input t_req r);
        t_rsp              res;
        int unsigned       n;
        int unsigned       idx;
        logic [63:0]       lim;
        logic [ADDR_W-1:0] ofs;
        res = '0;
        n = (m_slots > NSLOTS) ? NSLOTS : m_slots;
        case (r.opcode)
            OP_ALLOC: begin
                if (r.request_size <= m_stride && m_head < NSLOTS) begin
                    res.slot_address = m_base + ADDR_W'(m_head) * ADDR_W'(m_stride);
                    res.granted = 1'b1;
                    m_head = m_link[m_head];
                    if (m_used != USED_MAX) m_used++;
                end
            end
            OP_FREE: begin
                // bounds are checked at full width; the pool may run past 2^48
                lim = 64'(m_base) + 64'(m_stride) * 64'(n);
                if (r.freed_address != '0 && m_stride != '0 && r.freed_address >= m_base
                        && 64'(r.freed_address) < lim) begin
                    ofs = r.freed_address - m_base;
                    idx = int'(ofs / m_stride);
                    if (idx < NSLOTS) begin
                        m_link[idx] = m_head;
                        m_head = idx;
                        if (m_used != '0) m_used--;
                        res.granted = 1'b1;
                    end
                end
            end
            OP_REBUILD: begin
                for (int unsigned i = 0; i < n; i++) begin
                    m_link[i] = (i + 1 < n) ? i + 1 : NSLOTS;
                end
                m_head = (n > 0) ? 0 : NSLOTS;
                m_used = '0;
            end
            default: ;
        endcase
        res.used_count = m_used;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_v);
        n_err++;
        if (n_err <= 50) begin
            $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want_v);
        end
    endtask

    // response check, config tracking and prediction, all on the sampled edge
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp pred;
        if (!i_rst_n) begin
            pool_reset();
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_rsp++;
                if (pending_rsp.size() == 0) begin
                    report_mismatch("response with no request pending", 64'(o_out_rsp),
                                    64'd0);
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_out_rsp.granted !== want.granted)
                        report_mismatch("granted", 64'(o_out_rsp.granted),
                                        64'(want.granted));
                    if (o_out_rsp.slot_address !== want.slot_address)
                        report_mismatch("slot_address", 64'(o_out_rsp.slot_address),
                                        64'(want.slot_address));
                    if (o_out_rsp.used_count !== want.used_count)
                        report_mismatch("used_count", 64'(o_out_rsp.used_count),
                                        64'(want.used_count));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE:   m_base   = i_cfg_wdata;
                    CFG_STRIDE: m_stride = i_cfg_wdata[STRIDE_W-1:0];
                    CFG_SLOTS:  m_slots  = i_cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                pred = pool_step(i_in_req);
                pending_rsp.push_back(pred);
                n_req++;
                if (pred.granted && i_in_req.opcode == OP_ALLOC) n_alloc_ok++;
                if (pred.granted && i_in_req.opcode == OP_FREE) n_free_ok++;
            end
        end
    end

    // response back-pressure: while out_idle_on is set, ready is dropped with about 13 percent chance
    always @(posedge i_clk) begin
        if (out_idle_on && $urandom_range(99) < 13) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_req mk_req(input t_op op, input logic [SIZE_W-1:0] size,
                                    input logic [ADDR_W-1:0] addr);
        t_req r;
        r.opcode        = op;
        r.request_size  = size;
        r.freed_address = addr;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand48();
        return {16'($urandom_range(16'hFFFF)), 32'($urandom)};
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(7))
            0: return SIZE_W'($urandom);
            1: return SIZE_W'(m_stride) + 1'b1;
            2: return SIZE_W'(m_stride);
            default: return SIZE_W'($urandom_range(0, m_stride));
        endcase
    endfunction

    // mostly addresses inside the pool, often misaligned; some null and out of range
    function automatic logic [ADDR_W-1:0] pick_free_addr();
        int unsigned n;
        logic [63:0] lim;
        n = (m_slots > NSLOTS) ? NSLOTS : m_slots;
        lim = 64'(m_base) + 64'(m_stride) * 64'(n);
        if (m_stride == '0 || n == 0) return ($urandom_range(1) == 0) ? m_base : rand48();
        case ($urandom_range(9))
            0: return '0;
            1: return rand48();
            2: return m_base - ADDR_W'($urandom_range(1, 16));
            3: return ADDR_W'(lim + 64'($urandom_range(0, 16)));
            default: return m_base + ADDR_W'($urandom_range(0, n - 1)) * m_stride
                            + ADDR_W'($urandom_range(0, m_stride - 1));
        endcase
    endfunction

    task automatic send_req(input t_req r);
        if (in_idle_on && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [STRIDE_W-1:0] stride,
                            input logic [CNT_W-1:0] slots);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_STRIDE;
        i_cfg_wdata <= ADDR_W'(stride);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_SLOTS;
        i_cfg_wdata <= ADDR_W'(slots);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_phases++;
    endtask

    task automatic test_empty_after_reset();
        send_req(mk_req(OP_ALLOC, '0, '0));
        send_req(mk_req(OP_FREE, '0, 48'd4096));
        send_req(mk_req(OP_NOP, '0, '0));
        send_req(mk_req(OP_REBUILD, '0, '0));
        send_req(mk_req(OP_ALLOC, '0, '0));
    endtask

    task automatic test_alloc_free_basics();
        wait_drained();
        set_pool(48'd4096, 17'd8, 11'd4);
        send_req(mk_req(OP_REBUILD, '0, '0));
        send_req(mk_req(OP_ALLOC, 20'd8, '0));
        send_req(mk_req(OP_ALLOC, 20'd9, '0));
        send_req(mk_req(OP_ALLOC, '1, '0));
        send_req(mk_req(OP_ALLOC, '0, '0));
        send_req(mk_req(OP_FREE, '0, '0));
        send_req(mk_req(OP_FREE, '0, 48'd4095));
        send_req(mk_req(OP_FREE, '0, 48'd4128));
        // misaligned pointer into slot 1, then the same slot again
        send_req(mk_req(OP_FREE, '0, 48'd4109));
        send_req(mk_req(OP_FREE, '0, 48'd4104));
        send_req(mk_req(OP_ALLOC, 20'd1, '0));
        send_req(mk_req(OP_FREE, '1, '1));
        send_req(mk_req(OP_NOP, '1, '1));
    endtask

    task automatic test_pool_edges();
        // zero stride: only a zero-byte allocate can succeed
        wait_drained();
        set_pool(48'd4096, 17'd0, 11'd4);
        send_req(mk_req(OP_REBUILD, '0, '0));
        send_req(mk_req(OP_ALLOC, '0, '0));
        send_req(mk_req(OP_ALLOC, 20'd1, '0));
        send_req(mk_req(OP_FREE, '0, 48'd4096));
        // pool straddles the top of the address space
        wait_drained();
        set_pool(ADDR_MAX - 48'd15, 17'd8, 11'd8);
        send_req(mk_req(OP_REBUILD, '0, '0));
        repeat (3) send_req(mk_req(OP_ALLOC, 20'd8, '0));
        send_req(mk_req(OP_FREE, '0, ADDR_MAX));
        send_req(mk_req(OP_FREE, '0, 48'd8));
        // widest stride, slot count above the pool size
        wait_drained();
        set_pool(rand48(), '1, '1);
        send_req(mk_req(OP_REBUILD, '0, '0));
        send_req(mk_req(OP_ALLOC, 20'h1FFFF, '0));
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0]   base;
        logic [STRIDE_W-1:0] stride;
        logic [CNT_W-1:0]    slots;
        int                  n_items;
        int                  alloc_pct;
        int                  rb_pct;
        int                  pick;
        t_req                r;
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: base = '0;
                1: base = ADDR_MAX - 48'd4095;
                2: base = 48'd4096;
                default: base = rand48();
            endcase
            case (ph % 6)
                0: stride = 17'd8;
                1: stride = 17'd65536;
                2: stride = '1;
                3: stride = (ph == 3) ? '0 : STRIDE_W'($urandom_range(8, 4096));
                default: stride = STRIDE_W'($urandom_range(8, 512));
            endcase
            case (ph)
                5: slots = 11'd1024;
                7: slots = '0;
                9: slots = '1;
                default: slots = CNT_W'($urandom_range(1, 24));
            endcase
            // big pools rebuild slowly: fewer items, rare rebuilds
            n_items   = (slots > 64) ? 60 : 130;
            rb_pct    = (slots > 64) ? 1 : 4;
            alloc_pct = $urandom_range(30, 60);
            wait_drained();
            in_idle_on  = (ph != 4);
            out_idle_on = (ph != 4);
            set_pool(base, stride, slots);
            send_req(mk_req(OP_REBUILD, SIZE_W'($urandom), rand48()));
            for (int i = 1; i < n_items; i++) begin
                pick = $urandom_range(99);
                if (pick < alloc_pct)
                    r = mk_req(OP_ALLOC, pick_size(), rand48());
                else if (pick < 97 - rb_pct)
                    r = mk_req(OP_FREE, SIZE_W'($urandom), pick_free_addr());
                else if (pick < 97)
                    r = mk_req(OP_REBUILD, SIZE_W'($urandom), rand48());
                else
                    r = mk_req(OP_NOP, SIZE_W'($urandom), rand48());
                send_req(r);
            end
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    task automatic test_self_linked_slot();
        wait_drained();
        set_pool(48'd4096, 17'd8, 11'd2);
        send_req(mk_req(OP_REBUILD, '0, '0));
        // freeing the head slot links it to itself, so allocates never run dry
        // and the used count climbs past the pool size
        send_req(mk_req(OP_FREE, '0, 48'd4096));
        repeat (30) send_req(mk_req(OP_ALLOC, SIZE_W'($urandom_range(0, 8)), rand48()));
        send_req(mk_req(OP_REBUILD, '0, '0));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_after_reset();
        test_alloc_free_basics();
        test_pool_edges();
        test_random_traffic();
        test_self_linked_slot();
        wait_drained();
        repeat (1100) @(posedge i_clk);
        $display("run covered %0d requests in %0d pool settings, %0d responses checked",
                 n_req, n_phases, n_rsp);
        $display("allocates granted %0d, frees accepted %0d, errors %0d",
                 n_alloc_ok, n_free_ok, n_err);
        if (n_err == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d responses still pending", pending_rsp.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
